// ===== sv/rmq_pkg.sv =====
// Shared types, codes and sizes for the retransmitting message queue.
package rmq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_ARGS        = 2;
    localparam int JOB_DEPTH       = 2;
    localparam int BYTE_W          = 8;
    localparam int CMD_W           = 3;
    localparam int NARG_W          = 2;
    localparam int COUNT_W         = 5;
    localparam int CFG_IDX_W       = 2;

    localparam logic [BYTE_W-1:0] FAST_RETRY_RST = 8'd5;
    localparam logic [BYTE_W-1:0] GIVE_UP_RST    = 8'd16;
    localparam logic [BYTE_W-1:0] ACK_CODE_RST   = 8'd0;
    localparam logic [BYTE_W-1:0] TICKS_MAX      = 8'd255;

    typedef enum logic [CMD_W-1:0] {
        CMD_SEND        = 3'd0,
        CMD_ACK         = 3'd1,
        CMD_TICK        = 3'd2,
        CMD_CLEAR       = 3'd3,
        CMD_RECONNECT   = 3'd4,
        CMD_FORCE_ERROR = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        LINK_RUNNING = 2'd0,
        LINK_PENDING = 2'd1,
        LINK_ERROR   = 2'd2
    } t_link;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAST_RETRY = 2'd0,
        CFG_GIVE_UP    = 2'd1,
        CFG_ACK_CODE   = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        FS_IDLE = 1'b0,
        FS_READ = 1'b1
    } t_front_state;

    typedef enum logic {
        JOB_STATUS = 1'b0,
        JOB_FRAME  = 1'b1
    } t_job_kind;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BYTE_W-1:0] msg_code;
        logic [BYTE_W-1:0] arg_first;
        logic [BYTE_W-1:0] arg_second;
        logic [NARG_W-1:0] arg_count;
    } t_in_item;

    typedef struct packed {
        logic               byte_valid;
        logic [BYTE_W-1:0]  tx_byte;
        logic               frame_last;
        logic [1:0]         link_state;
        logic [COUNT_W-1:0] queue_count;
        logic               push_dropped;
    } t_out_item;

    // One stored frame: code, argument bytes, argument count, sequence number
    typedef struct packed {
        logic [BYTE_W-1:0] code;
        logic [BYTE_W-1:0] arg_first;
        logic [BYTE_W-1:0] arg_second;
        logic [NARG_W-1:0] nargs;
        logic [BYTE_W-1:0] seq;
    } t_entry;

    typedef struct packed {
        logic [1:0]         link_state;
        logic [COUNT_W-1:0] queue_count;
        logic               push_dropped;
    } t_status;

    typedef struct packed {
        t_job_kind kind;
        t_entry    entry;
        t_status   status;
    } t_job;

endpackage

// ===== sv/retransmitting_message_queue.sv =====
// Top level: stop-and-wait sender with a frame queue and retry timer.
// Path: job queue, then output register; a frame from the store first passes the registered store read.
// Throughput: one result item per cycle from the output register while the output is not stalled;
// a command yields 1 to 4 items. The front end takes a command every cycle while the two-entry job
// queue has room, but stalls while it reads the frame store.
// Reset: synchronous, active low; clears queue pointers, counters and link state and loads the
// register defaults. The frame store is not cleared.
module retransmitting_message_queue #(
    parameter int QUEUE_DEPTH = rmq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  rmq_pkg::t_in_item             i_in_item,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    output rmq_pkg::t_out_item            o_out_item,
    input  logic                          i_out_stall,
    input  logic                          i_cfg_we,
    input  logic [rmq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rmq_pkg::BYTE_W-1:0]    i_cfg_data
);
    import rmq_pkg::*;

    logic job_push, job_full, job_avail, job_pop;
    t_job push_job, head_job;

    rmq_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_job_full (job_full),
        .o_job_push (job_push),
        .o_job      (push_job)
    );

    rmq_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (push_job),
        .i_pop   (job_pop),
        .o_full  (job_full),
        .o_avail (job_avail),
        .o_job   (head_job)
    );

    rmq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_avail (job_avail),
        .i_job       (head_job),
        .o_job_pop   (job_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== sv/rmq_front.sv =====
// Front end: takes commands, keeps the frame store and link state, issues transmit jobs.
module rmq_front #(
    parameter int QUEUE_DEPTH = rmq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  rmq_pkg::t_in_item                   i_in_item,
    output logic                                o_in_stall,
    input  logic                                i_cfg_we,
    input  logic [rmq_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rmq_pkg::BYTE_W-1:0]          i_cfg_data,
    input  logic                                i_job_full,
    output logic                                o_job_push,
    output rmq_pkg::t_job                       o_job
);
    import rmq_pkg::*;

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    t_front_state      r_state, n_state;
    logic [IW-1:0]     r_head, n_head;
    logic [FW-1:0]     r_fill, n_fill;
    logic [BYTE_W-1:0] r_seq, n_seq;
    logic [BYTE_W-1:0] r_ticks, n_ticks;
    t_link             r_link, n_link;
    t_status           r_pend_status, n_pend_status;
    logic [BYTE_W-1:0] r_fast, r_give, r_ack_code;

    t_entry            r_mem [QUEUE_DEPTH];
    t_entry            r_rd_data;

    logic              accept;
    logic              mem_we;
    logic              go_read;
    logic [FW:0]       tail_sum;
    logic [IW-1:0]     tail;
    logic [IW-1:0]     head_inc;
    logic [NARG_W-1:0] na;
    t_entry            in_entry;
    t_entry            ack_entry;
    t_entry            direct_entry;
    logic              direct_frame;
    logic              dropped;
    t_status           status;

    assign tail_sum = (FW+1)'(r_head) + (FW+1)'(r_fill);
    assign tail     = (tail_sum >= (FW+1)'(QUEUE_DEPTH))
                    ? IW'(tail_sum - (FW+1)'(QUEUE_DEPTH)) : IW'(tail_sum);
    assign head_inc = (r_head == IW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;

    // Clamp the argument count and zero the bytes it does not cover
    assign na = (i_in_item.arg_count > NARG_W'(MAX_ARGS))
              ? NARG_W'(MAX_ARGS) : i_in_item.arg_count;
    always_comb begin
        in_entry.code       = i_in_item.msg_code;
        in_entry.arg_first  = (na > 2'd0) ? i_in_item.arg_first  : '0;
        in_entry.arg_second = (na > 2'd1) ? i_in_item.arg_second : '0;
        in_entry.nargs      = na;
        in_entry.seq        = r_seq;
        ack_entry.code       = r_ack_code;
        ack_entry.arg_first  = '0;
        ack_entry.arg_second = '0;
        ack_entry.nargs      = '0;
        ack_entry.seq        = '0;
    end

    assign o_in_stall = !(r_state == FS_IDLE && !i_job_full);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_fill        = r_fill;
        n_seq         = r_seq;
        n_ticks       = r_ticks;
        n_link        = r_link;
        n_pend_status = r_pend_status;
        mem_we        = 1'b0;
        go_read       = 1'b0;
        direct_frame  = 1'b0;
        direct_entry  = in_entry;
        dropped       = 1'b0;
        o_job_push    = 1'b0;
        o_job         = '0;

        if (accept) begin
            case (i_in_item.command)
                CMD_SEND: begin
                    n_link = LINK_PENDING;
                    n_seq  = r_seq + 1'b1;
                    if (r_fill >= FW'(QUEUE_DEPTH)) begin
                        dropped = 1'b1;
                    end else begin
                        mem_we = 1'b1;
                        n_fill = r_fill + 1'b1;
                        // Only entry: transmit straight from the command
                        if (r_fill == '0) begin
                            direct_frame = 1'b1;
                        end
                    end
                end
                CMD_ACK: begin
                    n_ticks = '0;
                    if (r_fill != '0) begin
                        n_head = head_inc;
                        n_fill = r_fill - 1'b1;
                    end
                    if (r_fill > FW'(1)) begin
                        go_read = 1'b1;
                    end else begin
                        n_link = LINK_RUNNING;
                    end
                end
                CMD_TICK: begin
                    if (r_fill != '0) begin
                        if (r_ticks != '0) begin
                            if (r_ticks < r_fast || (r_ticks < r_give && !r_ticks[0])) begin
                                go_read = 1'b1;
                            end else if (r_ticks >= r_give) begin
                                n_link = LINK_ERROR;
                            end
                        end
                        if (r_ticks != TICKS_MAX) begin
                            n_ticks = r_ticks + 1'b1;
                        end
                    end
                end
                CMD_CLEAR: begin
                    n_head = '0;
                    n_fill = '0;
                end
                CMD_RECONNECT: begin
                    n_link       = LINK_RUNNING;
                    n_seq        = 8'd1;
                    n_ticks      = '0;
                    direct_frame = 1'b1;
                    direct_entry = ack_entry;
                end
                CMD_FORCE_ERROR: begin
                    n_link = LINK_ERROR;
                end
                default: begin
                end
            endcase
        end

        status.link_state   = n_link;
        status.queue_count  = COUNT_W'(n_fill);
        status.push_dropped = dropped;

        case (r_state)
            FS_IDLE: begin
                if (accept) begin
                    if (go_read) begin
                        n_pend_status = status;
                        n_state       = FS_READ;
                    end else begin
                        o_job_push   = 1'b1;
                        o_job.kind   = direct_frame ? JOB_FRAME : JOB_STATUS;
                        o_job.entry  = direct_entry;
                        o_job.status = status;
                    end
                end
            end
            FS_READ: begin
                o_job_push   = 1'b1;
                o_job.kind   = JOB_FRAME;
                o_job.entry  = r_rd_data;
                o_job.status = r_pend_status;
                n_state      = FS_IDLE;
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= FS_IDLE;
            r_head     <= '0;
            r_fill     <= '0;
            r_seq      <= '0;
            r_ticks    <= '0;
            r_link     <= LINK_RUNNING;
            r_fast     <= FAST_RETRY_RST;
            r_give     <= GIVE_UP_RST;
            r_ack_code <= ACK_CODE_RST;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fill  <= n_fill;
            r_seq   <= n_seq;
            r_ticks <= n_ticks;
            r_link  <= n_link;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FAST_RETRY: r_fast     <= i_cfg_data;
                    CFG_GIVE_UP:    r_give     <= i_cfg_data;
                    CFG_ACK_CODE:   r_ack_code <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_status <= n_pend_status;
    end

    // Frame store: one write port at the tail, one registered read at the head
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[tail] <= in_entry;
        end
        if (go_read) begin
            r_rd_data <= r_mem[n_head];
        end
    end

endmodule

// ===== sv/rmq_job_fifo.sv =====
// Short job queue between the front end and the byte sender.
module rmq_job_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rmq_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_avail,
    output rmq_pkg::t_job o_job
);
    import rmq_pkg::*;

    localparam int PW = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int CW = $clog2(JOB_DEPTH + 1);

    t_job          r_buf [JOB_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(JOB_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_job   = r_buf[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(JOB_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(JOB_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wr] <= i_job;
        end
    end

endmodule

// ===== sv/rmq_back.sv =====
// Byte sender: walks each frame job one byte per transfer into the output register; a status job gives one item.
module rmq_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_avail,
    input  rmq_pkg::t_job     i_job,
    output logic              o_job_pop,
    output logic              o_out_valid,
    output rmq_pkg::t_out_item o_out_item,
    input  logic              i_out_stall
);
    import rmq_pkg::*;

    logic [1:0] r_idx, n_idx;
    logic       r_out_valid;
    t_out_item  r_out_item;
    t_out_item  item;
    logic       load;
    logic       last;

    assign load = !r_out_valid || !i_out_stall;

    always_comb begin
        item.link_state   = i_job.status.link_state;
        item.queue_count  = i_job.status.queue_count;
        item.push_dropped = i_job.status.push_dropped;
        last              = 1'b1;
        item.byte_valid   = 1'b0;
        item.tx_byte      = '0;
        if (i_job.kind == JOB_FRAME) begin
            item.byte_valid = 1'b1;
            last            = (r_idx == i_job.entry.nargs + 2'd1);
            if (r_idx == 2'd0) begin
                item.tx_byte = i_job.entry.code;
            end else if (r_idx <= i_job.entry.nargs) begin
                item.tx_byte = (r_idx == 2'd1) ? i_job.entry.arg_first
                                               : i_job.entry.arg_second;
            end else begin
                item.tx_byte = i_job.entry.seq;
            end
        end
        item.frame_last = last;

        o_job_pop = load && i_job_avail && last;
        n_idx     = r_idx;
        if (load && i_job_avail) begin
            n_idx = last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_out_valid <= i_job_avail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_job_avail) begin
            r_out_item <= item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== sv/rmq_checker.sv =====
// Port checker for the retransmitting message queue, bound to the top level.
module rmq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input rmq_pkg::t_out_item o_out_item
);
    import rmq_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("stalled result dropped");

    // A status-only item closes its command and carries no byte
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.byte_valid |->
            o_out_item.frame_last && o_out_item.tx_byte == '0)
        else $error("status item malformed");

    // A frame continues without a gap after a non-final transfer
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_item.frame_last |=>
            o_out_valid && o_out_item.byte_valid)
        else $error("frame interrupted");

    // Status fields stay the same across all items of one command
    a_same_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_item.frame_last |=>
            o_out_item.link_state == $past(o_out_item.link_state) &&
            o_out_item.queue_count == $past(o_out_item.queue_count) &&
            o_out_item.push_dropped == $past(o_out_item.push_dropped))
        else $error("status changed within a frame");

endmodule

bind retransmitting_message_queue rmq_checker u_rmq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
